// ===== rtl/core/ctse_pkg.sv =====
// ----------------------------------------------------------------------------
// ctse_pkg
// Shared sizes, codes and types of the column table scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ctse_pkg;

  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned MAX_COLS   = 8;
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned ADDR_W     = ROW_W + COL_W;
  localparam int unsigned DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ANS_W      = 45;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned RCNT_W     = 11;
  localparam int unsigned CCNT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUT      = 3'd0,
    OP_GET      = 3'd1,
    OP_COL_SUM  = 3'd2,
    OP_PRED_SUM = 3'd3,
    OP_PRED_ALL = 3'd4,
    OP_PRED_UPD = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1
  } cfg_idx_e;

  // What the datapath does with the word that comes back from the table.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_PUT,
    ACT_GET,
    ACT_ADD,
    ACT_ADD_IF,
    ACT_GT_ADD,
    ACT_FLAG_GT,
    ACT_AND_LT_B,
    ACT_FLAG_LT,
    ACT_HOLD,
    ACT_UPD
  } act_e;

  typedef struct packed {
    logic             start;
    logic             in_range;
    logic             issue;
    act_e             act;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } ctse_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic signed [31:0] value;
    logic signed [31:0] threshold_a;
    logic signed [31:0] threshold_b;
  } ctse_in_t;

  typedef struct packed {
    logic signed [ANS_W-1:0] answer;
    logic                    in_range;
  } ctse_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctse_if.sv =====
// ----------------------------------------------------------------------------
// ctse_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctse_in_if;
  import ctse_pkg::*;
  logic     valid;
  logic     ready;
  ctse_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctse_out_if;
  import ctse_pkg::*;
  logic      valid;
  logic      ready;
  ctse_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ctse_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctse_ctrl
// Command sequencer: configuration registers, row and step counters, FSM.
// ----------------------------------------------------------------------------
`default_nettype none

module ctse_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctse_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctse_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ctse_pkg::OP_W-1:0]       op_i,
  input  logic [ctse_pkg::ROW_W-1:0]      row_i,
  input  logic [ctse_pkg::COL_W-1:0]      col_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output ctse_pkg::ctse_cmd_t            cmd_o
);
  import ctse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [RCNT_W-1:0]   row_count_q;
  logic [CCNT_W-1:0]   col_count_q;
  logic [OP_W-1:0]     op_q;
  logic [ROW_W-1:0]    prow_q;
  logic [COL_W-1:0]    pcol_q;
  logic [ROW_W:0]      row_q, row_d;
  logic [COL_W-1:0]    step_q, step_d;
  logic                out_valid_q, out_valid_d;

  logic [ROW_W:0]      nr;
  logic [COL_W:0]      nc;
  logic                accept;
  logic                in_range;
  logic                has_work;
  logic                single;
  logic                last_step;
  logic                last_row;
  act_e                act;
  logic [COL_W-1:0]    col_sel;
  logic [ROW_W-1:0]    row_sel;

  assign nr = (row_count_q > RCNT_W'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS)
                                                 : (ROW_W+1)'(row_count_q);
  assign nc = (col_count_q > CCNT_W'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS)
                                                 : (COL_W+1)'(col_count_q);

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign in_range = ((op_i == OP_PUT) || (op_i == OP_GET)) &&
                    ((ROW_W+1)'(row_i) < nr) && ((COL_W+1)'(col_i) < nc);

  always_comb begin
    case (op_i)
      OP_PUT, OP_GET: has_work = in_range;
      OP_COL_SUM:     has_work = (nr != '0) && (nc >= (COL_W+1)'(1));
      OP_PRED_SUM:    has_work = (nr != '0) && (nc >= (COL_W+1)'(3));
      OP_PRED_ALL:    has_work = (nr != '0) && (nc >= (COL_W+1)'(1));
      OP_PRED_UPD:    has_work = (nr != '0) && (nc >= (COL_W+1)'(4));
      default:        has_work = 1'b0;
    endcase
  end

  // Step table: which column is read in each step of a row and what is done with it.
  always_comb begin
    single    = 1'b0;
    last_step = 1'b1;
    act       = ACT_NONE;
    col_sel   = '0;
    case (op_q)
      OP_PUT: begin
        single  = 1'b1;
        act     = ACT_PUT;
        col_sel = pcol_q;
      end
      OP_GET: begin
        single  = 1'b1;
        act     = ACT_GET;
        col_sel = pcol_q;
      end
      OP_COL_SUM: begin
        act = ACT_ADD;
      end
      OP_PRED_SUM: begin
        last_step = (step_q == COL_W'(2));
        if (step_q == COL_W'(0)) begin
          act     = ACT_FLAG_GT;
          col_sel = COL_W'(1);
        end else if (step_q == COL_W'(1)) begin
          act     = ACT_AND_LT_B;
          col_sel = COL_W'(2);
        end else begin
          act     = ACT_ADD_IF;
        end
      end
      OP_PRED_ALL: begin
        last_step = (((COL_W+1)'(step_q) + (COL_W+1)'(1)) == nc);
        col_sel   = step_q;
        act       = (step_q == COL_W'(0)) ? ACT_GT_ADD : ACT_ADD_IF;
      end
      OP_PRED_UPD: begin
        last_step = (step_q == COL_W'(2));
        if (step_q == COL_W'(0)) begin
          act     = ACT_FLAG_LT;
        end else if (step_q == COL_W'(1)) begin
          act     = ACT_HOLD;
          col_sel = COL_W'(2);
        end else begin
          act     = ACT_UPD;
          col_sel = COL_W'(3);
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  assign row_sel  = single ? prow_q : row_q[ROW_W-1:0];
  assign last_row = single || ((row_q + (ROW_W+1)'(1)) == nr);

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          row_d   = '0;
          step_d  = '0;
          state_d = has_work ? S_SCAN : S_DRAIN;
        end
      end
      S_SCAN: begin
        if (last_step) begin
          step_d = '0;
          row_d  = row_q + (ROW_W+1)'(1);
          if (last_row) begin
            state_d = S_DRAIN;
          end
        end else begin
          step_d = step_q + COL_W'(1);
        end
      end
      S_DRAIN: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      row_count_q <= '0;
      col_count_q <= '0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_COUNT: row_count_q <= cfg_data_i;
          CFG_COL_COUNT: col_count_q <= cfg_data_i[CCNT_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      prow_q <= row_i;
      pcol_q <= col_i;
    end
  end

  always_comb begin
    cmd_o.start    = accept;
    cmd_o.in_range = in_range;
    cmd_o.issue    = (state_q == S_SCAN);
    cmd_o.act      = (state_q == S_SCAN) ? act : ACT_NONE;
    cmd_o.row      = row_sel;
    cmd_o.col      = col_sel;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctse_dp.sv =====
// ----------------------------------------------------------------------------
// ctse_dp
// Table memory, predicate flag and the 45-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ctse_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ctse_pkg::ctse_cmd_t               cmd_i,
  input  logic signed [ctse_pkg::DATA_W-1:0] value_i,
  input  logic signed [ctse_pkg::DATA_W-1:0] ta_i,
  input  logic signed [ctse_pkg::DATA_W-1:0] tb_i,
  output logic signed [ctse_pkg::ANS_W-1:0]  answer_o,
  output logic                              in_range_o
);
  import ctse_pkg::*;

  logic [DATA_W-1:0]        table_mem [DEPTH];
  logic [ADDR_W-1:0]        raddr;
  logic [DATA_W-1:0]        rdata_q;
  act_e                     tag_act_q;
  logic [ADDR_W-1:0]        tag_addr_q;

  logic signed [DATA_W-1:0] value_q, ta_q, tb_q;
  logic [DATA_W-1:0]        hold_q, hold_d;
  logic                     flag_q, flag_d;
  logic signed [ANS_W-1:0]  acc_q, acc_d;
  logic                     in_range_q, in_range_d;

  logic                     wr_en;
  logic [DATA_W-1:0]        wdata;
  logic signed [DATA_W-1:0] word;
  logic signed [ANS_W-1:0]  word_ext;
  logic                     gt_a, lt_a, lt_b;

  // Column-major layout with a fixed stride of MAX_ROWS entries per column.
  assign raddr = {cmd_i.col, cmd_i.row};

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= table_mem[raddr];
    end
    if (wr_en) begin
      table_mem[tag_addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_act_q <= ACT_NONE;
    end else begin
      tag_act_q <= cmd_i.act;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_addr_q <= raddr;
  end

  assign word     = $signed(rdata_q);
  assign word_ext = {{(ANS_W-DATA_W){rdata_q[DATA_W-1]}}, rdata_q};
  assign gt_a     = word > ta_q;
  assign lt_a     = word < ta_q;
  assign lt_b     = word < tb_q;

  always_comb begin
    wr_en      = 1'b0;
    wdata      = value_q;
    hold_d     = hold_q;
    flag_d     = flag_q;
    acc_d      = acc_q;
    in_range_d = in_range_q;
    case (tag_act_q)
      ACT_PUT: begin
        wr_en = 1'b1;
      end
      ACT_GET: begin
        acc_d = word_ext;
      end
      ACT_ADD: begin
        acc_d = acc_q + word_ext;
      end
      ACT_ADD_IF: begin
        if (flag_q) begin
          acc_d = acc_q + word_ext;
        end
      end
      ACT_GT_ADD: begin
        flag_d = gt_a;
        if (gt_a) begin
          acc_d = acc_q + word_ext;
        end
      end
      ACT_FLAG_GT: begin
        flag_d = gt_a;
      end
      ACT_AND_LT_B: begin
        flag_d = flag_q && lt_b;
      end
      ACT_FLAG_LT: begin
        flag_d = lt_a;
      end
      ACT_HOLD: begin
        hold_d = rdata_q;
      end
      ACT_UPD: begin
        if (flag_q) begin
          wr_en = 1'b1;
          wdata = hold_q + rdata_q;
          acc_d = acc_q + ANS_W'(1);
        end
      end
      default: ;
    endcase
    if (cmd_i.start) begin
      acc_d      = '0;
      flag_d     = 1'b0;
      in_range_d = cmd_i.in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    flag_q     <= flag_d;
    acc_q      <= acc_d;
    in_range_q <= in_range_d;
    if (cmd_i.start) begin
      value_q <= value_i;
      ta_q    <= ta_i;
      tb_q    <= tb_i;
    end
  end

  assign answer_o   = acc_q;
  assign in_range_o = in_range_q;

endmodule

`default_nettype wire

// ===== rtl/core/column_table_scan_engine.sv =====
// ----------------------------------------------------------------------------
// column_table_scan_engine
// Column-major table of signed 32-bit entries with put, get, column sums and predicated scans.
// ----------------------------------------------------------------------------
// A command reads table words one per cycle on the table's single read port and offers
// its result word once the last word read has been applied. An in-range put or get
// reads one word; a scan with rows in use and enough columns reads rows * steps words
// (steps: 1 column sum, 3 predicated sum and update, col_count capped at MAX_COLS for
// the all-columns sum). Any other command reads none. One command is in flight, and the
// next is taken the cycle after the result word is taken. Reset clears the counts and
// handshake state; the table is undefined until written.
`default_nettype none

module column_table_scan_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctse_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctse_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ctse_in_if.sink                        in_ch,
  ctse_out_if.source                     out_ch
);
  import ctse_pkg::*;

  // The controller walks rows and steps and issues one table read per cycle,
  // each tagged with the action that the datapath applies in the following cycle,
  // when the registered read word arrives.
  ctse_cmd_t               cmd;
  logic signed [ANS_W-1:0] answer;
  logic                    in_range;

  ctse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .op_i        (in_ch.data.op),
    .row_i       (in_ch.data.row),
    .col_i       (in_ch.data.col),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd)
  );

  // The datapath owns the table memory, the predicate flag, the held column 2
  // word for updates and the accumulator that becomes the result word.
  ctse_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (in_ch.data.value),
    .ta_i       (in_ch.data.threshold_a),
    .tb_i       (in_ch.data.threshold_b),
    .answer_o   (answer),
    .in_range_o (in_range)
  );

  // The result register holds until the sink takes the word.
  assign out_ch.data.answer   = answer;
  assign out_ch.data.in_range = in_range;

endmodule

`default_nettype wire

// ===== rtl/core/ctse_checker.sv =====
// ----------------------------------------------------------------------------
// ctse_checker
// Port-level checks of the column table scan engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctse_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ctse_pkg::ctse_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i)
    else $error("command taken while a result word waits");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command taken before the first finished");

endmodule

bind column_table_scan_engine ctse_checker u_ctse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);

`default_nettype wire
